// ===== hdl/plils_pkg.sv =====
package plils_pkg;

	localparam int VALUE_WIDTH = 64;
	localparam int PROD_W      = VALUE_WIDTH + 4;
	localparam int TDATA_W     = 72;

	localparam logic [PROD_W-1:0] CAP = PROD_W'(1) << (VALUE_WIDTH - 1);

	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_TILDE = 8'h7e;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_B  = 8'h62;
	localparam logic [7:0] CH_LC_F  = 8'h66;
	localparam logic [7:0] CH_LC_X  = 8'h78;

	localparam logic [4:0] NO_DIGIT = 5'd16;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_PREFIX,
		PH_ZERO,
		PH_ZB,
		PH_ZX,
		PH_DIGITS
	} phase_t;

	typedef enum logic [1:0] {
		RX_DEC,
		RX_BIN,
		RX_OCT,
		RX_HEX
	} radix_t;

	typedef enum logic [1:0] {
		KIND_INT,
		KIND_PAREN,
		KIND_ERR
	} kind_t;

	typedef enum logic [3:0] {
		ERR_NONE,
		ERR_DOUBLE_MINUS,
		ERR_MINUS_ORDER,
		ERR_TRIPLE_NOT,
		ERR_DOUBLE_INV,
		ERR_PREFIX,
		ERR_OVERFLOW,
		ERR_FRAC_BASE,
		ERR_INV_FRAC,
		ERR_ILLEGAL,
		ERR_NO_VALUE,
		ERR_FRAC_UNSUP
	} err_t;

	typedef struct packed {
		logic neg;
		logic lnot;
		logic dnot;
		logic inv;
	} flags_t;

	typedef struct packed {
		phase_t                 phase;
		flags_t                 flags;
		radix_t                 radix;
		logic [VALUE_WIDTH-1:0] mag;
		logic                   ovf;
	} scan_state_t;

	typedef struct packed {
		logic        emit;
		kind_t       kind;
		logic [63:0] value;
		err_t        err;
		flags_t      flags;
		logic        consumed;
	} scan_result_t;

	localparam scan_state_t SCAN_RESET = '{
		phase: PH_IDLE,
		flags: '0,
		radix: RX_DEC,
		mag:   '0,
		ovf:   1'b0
	};

	function automatic logic [4:0] base_of(input radix_t rx);
		logic [4:0] b;
		case (rx)
			RX_BIN:  b = 5'd2;
			RX_OCT:  b = 5'd8;
			RX_HEX:  b = 5'd16;
			default: b = 5'd10;
		endcase
		return b;
	endfunction

	function automatic logic [4:0] digit_of(input logic [7:0] ch, input radix_t rx);
		logic [4:0] d;
		d = NO_DIGIT;
		if (ch >= CH_0 && ch <= CH_9)
			d = 5'(ch - CH_0);
		else if (rx == RX_HEX && ch >= CH_LC_A && ch <= CH_LC_F)
			d = 5'(ch - CH_LC_A) + 5'd10;
		if (d >= base_of(rx))
			d = NO_DIGIT;
		return d;
	endfunction

endpackage

// ===== hdl/plils_step.sv =====
module plils_step (
	input  plils_pkg::scan_state_t  cur,
	input  logic [7:0]              ch,
	output plils_pkg::scan_state_t  nxt,
	output plils_pkg::scan_result_t res
);

	localparam int VW = plils_pkg::VALUE_WIDTH;

	logic                          is_ws;
	logic [4:0]                    d_rad;
	logic [4:0]                    d_oct;
	logic [4:0]                    d_dec;
	logic [4:0]                    d_bin;
	logic [4:0]                    d_hex;
	logic [plils_pkg::PROD_W-1:0]  mag_ext;
	logic [plils_pkg::PROD_W-1:0]  prod;
	logic                          acc_ovf;
	logic [VW-1:0]                 acc_mag;
	logic [VW-1:0]                 lit;
	logic                          any_flag;

	logic                          ts_emit;
	plils_pkg::kind_t              ts_kind;
	plils_pkg::err_t               ts_err;
	plils_pkg::kind_t              el_kind;
	plils_pkg::err_t               el_err;
	logic                          el_consumed;

	always_comb begin
		is_ws = (ch == plils_pkg::CH_SP) || (ch == plils_pkg::CH_TAB) ||
			(ch == plils_pkg::CH_NL);
		d_rad = plils_pkg::digit_of(ch, cur.radix);
		d_oct = plils_pkg::digit_of(ch, plils_pkg::RX_OCT);
		d_dec = plils_pkg::digit_of(ch, plils_pkg::RX_DEC);
		d_bin = plils_pkg::digit_of(ch, plils_pkg::RX_BIN);
		d_hex = plils_pkg::digit_of(ch, plils_pkg::RX_HEX);
		any_flag = cur.flags.neg | cur.flags.lnot | cur.flags.dnot | cur.flags.inv;
	end

	// digit step: mag * base + d, checked against 2^(VW-1)
	always_comb begin
		mag_ext = plils_pkg::PROD_W'(cur.mag);
		case (cur.radix)
			plils_pkg::RX_BIN: prod = mag_ext << 1;
			plils_pkg::RX_OCT: prod = mag_ext << 3;
			plils_pkg::RX_HEX: prod = mag_ext << 4;
			default:           prod = (mag_ext << 3) + (mag_ext << 1);
		endcase
		prod = prod + plils_pkg::PROD_W'(d_rad[3:0]);
		acc_ovf = cur.ovf || (prod > plils_pkg::CAP);
		acc_mag = acc_ovf ? cur.mag : prod[VW-1:0];
	end

	// token start decode
	always_comb begin
		ts_emit = 1'b0;
		ts_kind = plils_pkg::KIND_ERR;
		ts_err  = plils_pkg::ERR_NONE;
		case (ch) inside
			plils_pkg::CH_MINUS: begin
				ts_emit = any_flag;
				ts_err  = cur.flags.neg ? plils_pkg::ERR_DOUBLE_MINUS
					: plils_pkg::ERR_MINUS_ORDER;
			end
			plils_pkg::CH_BANG: begin
				ts_emit = cur.flags.dnot;
				ts_err  = plils_pkg::ERR_TRIPLE_NOT;
			end
			plils_pkg::CH_TILDE: begin
				ts_emit = cur.flags.inv;
				ts_err  = plils_pkg::ERR_DOUBLE_INV;
			end
			[plils_pkg::CH_0:plils_pkg::CH_9]: begin
				ts_emit = 1'b0;
			end
			plils_pkg::CH_LPAR: begin
				ts_emit = 1'b1;
				ts_kind = plils_pkg::KIND_PAREN;
			end
			default: begin
				ts_emit = 1'b1;
				ts_err  = any_flag ? plils_pkg::ERR_ILLEGAL : plils_pkg::ERR_NO_VALUE;
			end
		endcase
	end

	// literal end decode
	always_comb begin
		lit = cur.flags.neg ? (VW'(0) - cur.mag) : cur.mag;
		el_kind     = plils_pkg::KIND_ERR;
		el_err      = plils_pkg::ERR_NONE;
		el_consumed = 1'b0;
		if (ch == plils_pkg::CH_DOT) begin
			el_consumed = 1'b1;
			if (cur.radix != plils_pkg::RX_DEC)
				el_err = plils_pkg::ERR_FRAC_BASE;
			else if (cur.flags.inv)
				el_err = plils_pkg::ERR_INV_FRAC;
			else
				el_err = plils_pkg::ERR_FRAC_UNSUP;
		end else if (cur.ovf ||
			(!cur.flags.neg && plils_pkg::PROD_W'(cur.mag) == plils_pkg::CAP)) begin
			el_err = plils_pkg::ERR_OVERFLOW;
		end else begin
			el_kind = plils_pkg::KIND_INT;
		end
	end

	// result
	always_comb begin
		res.emit     = 1'b0;
		res.kind     = plils_pkg::KIND_ERR;
		res.value    = '0;
		res.err      = plils_pkg::ERR_NONE;
		res.flags    = cur.flags;
		res.consumed = 1'b1;
		case (cur.phase)
			plils_pkg::PH_IDLE: begin
				res.emit = ts_emit && !is_ws;
				res.kind = ts_kind;
				res.err  = ts_err;
			end
			plils_pkg::PH_ZERO, plils_pkg::PH_DIGITS: begin
				if (cur.phase == plils_pkg::PH_ZERO)
					res.emit = (ch != plils_pkg::CH_LC_B) && (ch != plils_pkg::CH_LC_X) &&
						(d_dec == plils_pkg::NO_DIGIT);
				else
					res.emit = (d_rad == plils_pkg::NO_DIGIT);
				res.kind     = el_kind;
				res.err      = el_err;
				res.consumed = el_consumed;
				if (el_kind == plils_pkg::KIND_INT)
					res.value = 64'($signed(lit));
			end
			plils_pkg::PH_ZB: begin
				res.emit = (d_bin == plils_pkg::NO_DIGIT);
				res.err  = plils_pkg::ERR_PREFIX;
			end
			plils_pkg::PH_ZX: begin
				res.emit = (d_hex == plils_pkg::NO_DIGIT);
				res.err  = plils_pkg::ERR_PREFIX;
			end
			default: begin
				res.emit = ts_emit;
				res.kind = ts_kind;
				res.err  = ts_err;
			end
		endcase
	end

	// next state
	always_comb begin
		nxt = cur;
		if (res.emit) begin
			nxt = plils_pkg::SCAN_RESET;
		end else begin
			case (cur.phase)
				plils_pkg::PH_ZERO: begin
					if (ch == plils_pkg::CH_LC_B) begin
						nxt.phase = plils_pkg::PH_ZB;
					end else if (ch == plils_pkg::CH_LC_X) begin
						nxt.phase = plils_pkg::PH_ZX;
					end else begin
						nxt.phase = plils_pkg::PH_DIGITS;
						nxt.ovf   = 1'b0;
						if (d_oct != plils_pkg::NO_DIGIT) begin
							nxt.radix = plils_pkg::RX_OCT;
							nxt.mag   = VW'(d_oct[3:0]);
						end else begin
							nxt.radix = plils_pkg::RX_DEC;
							nxt.mag   = VW'(d_dec[3:0]);
						end
					end
				end
				plils_pkg::PH_ZB: begin
					nxt.phase = plils_pkg::PH_DIGITS;
					nxt.radix = plils_pkg::RX_BIN;
					nxt.mag   = VW'(d_bin[3:0]);
					nxt.ovf   = 1'b0;
				end
				plils_pkg::PH_ZX: begin
					nxt.phase = plils_pkg::PH_DIGITS;
					nxt.radix = plils_pkg::RX_HEX;
					nxt.mag   = VW'(d_hex[3:0]);
					nxt.ovf   = 1'b0;
				end
				plils_pkg::PH_DIGITS: begin
					nxt.mag = acc_mag;
					nxt.ovf = acc_ovf;
				end
				default: begin
					if (cur.phase != plils_pkg::PH_IDLE && cur.phase != plils_pkg::PH_PREFIX)
						nxt = plils_pkg::SCAN_RESET;
					if (!(cur.phase == plils_pkg::PH_IDLE && is_ws)) begin
						case (ch) inside
							plils_pkg::CH_MINUS: begin
								nxt.flags.neg = 1'b1;
								nxt.phase     = plils_pkg::PH_PREFIX;
							end
							plils_pkg::CH_BANG: begin
								nxt.flags.dnot = cur.flags.lnot;
								nxt.flags.lnot = 1'b1;
								nxt.phase      = plils_pkg::PH_PREFIX;
							end
							plils_pkg::CH_TILDE: begin
								nxt.flags.inv = 1'b1;
								nxt.phase     = plils_pkg::PH_PREFIX;
							end
							plils_pkg::CH_0: begin
								nxt.radix = plils_pkg::RX_DEC;
								nxt.mag   = '0;
								nxt.ovf   = 1'b0;
								nxt.phase = plils_pkg::PH_ZERO;
							end
							[plils_pkg::CH_1:plils_pkg::CH_9]: begin
								nxt.radix = plils_pkg::RX_DEC;
								nxt.mag   = VW'(d_dec[3:0]);
								nxt.ovf   = 1'b0;
								nxt.phase = plils_pkg::PH_DIGITS;
							end
							default: begin
								nxt.phase = plils_pkg::PH_IDLE;
							end
						endcase
					end
				end
			endcase
		end
	end

endmodule

// ===== hdl/prefixed_integer_literal_scanner.sv =====
// A character word is taken into the input register, and the result word that it produces is
// presented from the result register.
// Throughput: one character per cycle, unless a result waits at the output and the character
// ends a token; the digit step (shift-add and range compare) sits between the input register and the result register.
// The result register lets characters that end no token in while a result waits to be taken.
// Reset (arst_n low, asynchronous): scanner idle, prefixes clear, both registers empty.
module prefixed_integer_literal_scanner (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // [7:0] ch
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [63:0] literal_value, [67:64] error_code, [68] logical_not,
	// [69] double_not, [70] bit_invert, [71] char_consumed
	output logic [plils_pkg::TDATA_W-1:0] m_axis_tdata,
	output logic [1:0]                    m_axis_tuser   // [1:0] kind
);

	logic                    valid_s1;
	logic [7:0]              ch_s1;
	plils_pkg::scan_state_t  state_q;
	plils_pkg::scan_state_t  state_nxt;
	plils_pkg::scan_result_t res;
	logic                    valid_s2;
	plils_pkg::scan_result_t res_s2;
	logic                    out_free;
	logic                    advance;

	plils_step u_step (
		.cur (state_q),
		.ch  (ch_s1),
		.nxt (state_nxt),
		.res (res)
	);

	assign out_free      = !valid_s2 || m_axis_tready;
	assign advance       = valid_s1 && (!res.emit || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= plils_pkg::SCAN_RESET;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (advance)
				state_q <= state_nxt;
			if (out_free)
				valid_s2 <= advance && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			ch_s1 <= s_axis_tdata;
		if (advance && res.emit)
			res_s2 <= res;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {res_s2.consumed, res_s2.flags.inv, res_s2.flags.dnot,
		res_s2.flags.lnot, res_s2.err, res_s2.value};
	assign m_axis_tuser  = res_s2.kind;

endmodule

// ===== hdl/plils_check.sv =====
module plils_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [plils_pkg::TDATA_W-1:0] m_axis_tdata,
	input logic [1:0]                    m_axis_tuser
);

	// stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
			$stable(m_axis_tuser))
		else $error("result word changed while stalled");

	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tuser == plils_pkg::KIND_ERR) ==
			(m_axis_tdata[67:64] != plils_pkg::ERR_NONE)))
		else $error("error code disagrees with kind");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != plils_pkg::KIND_INT |-> m_axis_tdata[63:0] == 64'd0)
		else $error("non-literal word carries a value");

	a_int_unconsumed: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == plils_pkg::KIND_INT |-> !m_axis_tdata[71])
		else $error("literal claims its ending character");

	a_dnot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[69] |-> m_axis_tdata[68])
		else $error("double not without not");

endmodule

bind prefixed_integer_literal_scanner plils_check u_plils_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
